/* src/lat_pkg.sv */
// Shared types and constants for the live allocation tracker.
// Holds the request, result and slot layouts and the state encoding.
// No dependencies.
package lat_pkg;

    localparam int ADDR_W  = 64;
    localparam int SIZE_W  = 32;
    localparam int TOTAL_W = 48;
    localparam int COUNT_W = 7;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_REALLOC = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_NOT_FOUND  = 2'd1,
        STATUS_TABLE_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RELEASE,
        S_CHARGE,
        S_PEAK
    } state_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] new_address;
        logic [SIZE_W-1:0] size;
    } request_t;

    typedef struct packed {
        status_t            status;
        logic [SIZE_W-1:0]  prior_size;
        logic [TOTAL_W-1:0] live_bytes;
        logic [TOTAL_W-1:0] peak_bytes;
        logic [SIZE_W-1:0]  largest_request;
        logic [COUNT_W-1:0] live_count;
        logic [TOTAL_W-1:0] net_allocated;
    } result_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] size;
    } slot_t;

endpackage

/* src/lat_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* src/live_allocation_tracker.sv */
// Top level of the live allocation tracker: slot table scan and running totals.
// Depends on lat_pkg and lat_ram.
//
// Channel   Direction  Handshake               Payload
// request   in         start high, busy low    request (lat_pkg::request_t)
// result    out        done high for one cycle result  (lat_pkg::result_t)
//
// After reset a clearing pass writes every slot, with busy high.
// Alloc, free and realloc scan the slot RAM one entry per cycle from slot zero, stopping at
// the first hit; a miss at the last slot answers table full for alloc, else not found.
// A hit updates the totals in release, charge and peak; an unused command skips the scan.
// The result is held for one cycle only and cannot be stalled.
module live_allocation_tracker #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  lat_pkg::request_t  request,
    output logic               done,
    output lat_pkg::result_t   result
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int SW = $bits(lat_pkg::slot_t);
    localparam logic [lat_pkg::TOTAL_W-1:0] SAT = {lat_pkg::TOTAL_W{1'b1}};

    lat_pkg::state_t state_reg, state_next;
    logic [IW:0]     idx_reg, idx_next;
    logic [IW-1:0]   cmp_idx_reg, cmp_idx_next;
    logic            pend_reg, pend_next;
    logic [IW-1:0]   clr_idx_reg, clr_idx_next;
    lat_pkg::request_t req_reg, req_next;
    logic [lat_pkg::SIZE_W-1:0]  old_reg, old_next;
    logic [lat_pkg::TOTAL_W-1:0] live_reg, live_next;
    logic [lat_pkg::TOTAL_W-1:0] peak_reg, peak_next;
    logic [lat_pkg::SIZE_W-1:0]  largest_reg, largest_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [lat_pkg::TOTAL_W-1:0] net_reg, net_next;
    logic              done_reg, done_next;
    lat_pkg::result_t  result_reg, result_next;

    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    lat_pkg::slot_t    wr_slot;
    logic [SW-1:0]     rd_data;
    lat_pkg::slot_t    rd_slot;
    logic              hit;
    logic [lat_pkg::TOTAL_W:0] live_sum;
    logic [lat_pkg::TOTAL_W:0] net_sum;

    lat_ram #(
        .WIDTH (SW),
        .DEPTH (TABLE_ENTRIES)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_slot),
        .rd_addr (idx_reg[IW-1:0]),
        .rd_data (rd_data)
    );

    assign rd_slot  = lat_pkg::slot_t'(rd_data);
    assign hit      = (req_reg.cmd == lat_pkg::CMD_ALLOC) ? !rd_slot.valid
                    : (rd_slot.valid && (rd_slot.address == req_reg.address));
    assign live_sum = {1'b0, live_reg} + (lat_pkg::TOTAL_W + 1)'(req_reg.size);
    assign net_sum  = {1'b0, net_reg} + (lat_pkg::TOTAL_W + 1)'(req_reg.size);

    assign busy   = (state_reg != lat_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lat_pkg::S_CLEAR;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            clr_idx_reg <= '0;
            live_reg    <= '0;
            peak_reg    <= '0;
            largest_reg <= '0;
            count_reg   <= '0;
            net_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
            clr_idx_reg <= clr_idx_next;
            live_reg    <= live_next;
            peak_reg    <= peak_next;
            largest_reg <= largest_next;
            count_reg   <= count_next;
            net_reg     <= net_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        req_reg     <= req_next;
        old_reg     <= old_next;
        result_reg  <= result_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        pend_next    = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        clr_idx_next = clr_idx_reg;
        req_next     = req_reg;
        old_next     = old_reg;
        live_next    = live_reg;
        peak_next    = peak_reg;
        largest_next = largest_reg;
        count_next   = count_reg;
        net_next     = net_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        wr_en        = 1'b0;
        wr_addr      = cmp_idx_reg;
        wr_slot      = '0;

        result_next.status          = lat_pkg::STATUS_OK;
        result_next.prior_size      = '0;
        result_next.live_bytes      = live_reg;
        result_next.peak_bytes      = peak_reg;
        result_next.largest_request = largest_reg;
        result_next.live_count      = lat_pkg::COUNT_W'(count_reg);
        result_next.net_allocated   = net_reg;

        unique case (state_reg)
            lat_pkg::S_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_idx_reg;
                clr_idx_next = clr_idx_reg + IW'(1);
                if (clr_idx_reg == IW'(TABLE_ENTRIES - 1))
                begin
                    state_next = lat_pkg::S_IDLE;
                end
            end
            lat_pkg::S_IDLE:
            begin
                if (start)
                begin
                    req_next = request;
                    idx_next = '0;
                    case (request.cmd) inside
                        lat_pkg::CMD_ALLOC, lat_pkg::CMD_FREE, lat_pkg::CMD_REALLOC:
                        begin
                            state_next = lat_pkg::S_SCAN;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            lat_pkg::S_SCAN:
            begin
                if (idx_reg < (IW + 1)'(TABLE_ENTRIES))
                begin
                    pend_next    = 1'b1;
                    cmp_idx_next = idx_reg[IW-1:0];
                    idx_next     = idx_reg + (IW + 1)'(1);
                end
                if (pend_reg)
                begin
                    if (hit)
                    begin
                        pend_next  = 1'b0;
                        wr_en      = 1'b1;
                        state_next = lat_pkg::S_RELEASE;
                        case (req_reg.cmd)
                            lat_pkg::CMD_ALLOC:
                            begin
                                wr_slot  = '{valid: 1'b1, address: req_reg.address,
                                             size: req_reg.size};
                                old_next = '0;
                            end
                            lat_pkg::CMD_REALLOC:
                            begin
                                wr_slot  = '{valid: 1'b1, address: req_reg.new_address,
                                             size: req_reg.size};
                                old_next = rd_slot.size;
                            end
                            default:
                            begin
                                wr_slot  = '{valid: 1'b0, address: rd_slot.address,
                                             size: rd_slot.size};
                                old_next = rd_slot.size;
                            end
                        endcase
                    end
                    else if (cmp_idx_reg == IW'(TABLE_ENTRIES - 1))
                    begin
                        pend_next          = 1'b0;
                        done_next          = 1'b1;
                        state_next         = lat_pkg::S_IDLE;
                        result_next.status = (req_reg.cmd == lat_pkg::CMD_ALLOC)
                                           ? lat_pkg::STATUS_TABLE_FULL
                                           : lat_pkg::STATUS_NOT_FOUND;
                    end
                end
            end
            lat_pkg::S_RELEASE:
            begin
                live_next = (live_reg > lat_pkg::TOTAL_W'(old_reg))
                          ? live_reg - lat_pkg::TOTAL_W'(old_reg) : '0;
                if (req_reg.cmd == lat_pkg::CMD_REALLOC)
                begin
                    net_next = (net_reg > lat_pkg::TOTAL_W'(old_reg))
                             ? net_reg - lat_pkg::TOTAL_W'(old_reg) : '0;
                end
                if (req_reg.cmd == lat_pkg::CMD_ALLOC)
                begin
                    count_next = count_reg + CW'(1);
                end
                else if ((req_reg.cmd == lat_pkg::CMD_FREE) && (count_reg != '0))
                begin
                    count_next = count_reg - CW'(1);
                end
                state_next = lat_pkg::S_CHARGE;
            end
            lat_pkg::S_CHARGE:
            begin
                if (req_reg.cmd != lat_pkg::CMD_FREE)
                begin
                    live_next = live_sum[lat_pkg::TOTAL_W] ? SAT
                              : live_sum[lat_pkg::TOTAL_W-1:0];
                    net_next  = net_sum[lat_pkg::TOTAL_W] ? SAT
                              : net_sum[lat_pkg::TOTAL_W-1:0];
                    if (req_reg.size > largest_reg)
                    begin
                        largest_next = req_reg.size;
                    end
                end
                state_next = lat_pkg::S_PEAK;
            end
            lat_pkg::S_PEAK:
            begin
                if (live_reg > peak_reg)
                begin
                    peak_next = live_reg;
                end
                result_next.prior_size = old_reg;
                result_next.peak_bytes = peak_next;
                done_next  = 1'b1;
                state_next = lat_pkg::S_IDLE;
            end
            default:
            begin
                state_next = lat_pkg::S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_live_below_peak: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != lat_pkg::S_PEAK) |-> (live_reg <= peak_reg))
        else $error("live bytes exceed peak bytes");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_ENTRIES))
        else $error("live count exceeds table size");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted request neither started nor answered");

    a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (busy && !done_reg))
        else $error("slot write outside a command");
`endif

endmodule
